FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold at the same edge as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold at the edge after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bcie_pkg.sv
// ----------------------------------------------------------------------------
// bcie_pkg
// types and status codes for the bearer capability element decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcie_pkg;

    localparam int OCTET_W = 8;
    localparam int STATUS_W = 4;
    localparam int PROTO_W = 5;

    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 4'd1;
    localparam logic [STATUS_W-1:0] ST_OCT3_EXT  = 4'd2;
    localparam logic [STATUS_W-1:0] ST_OCT4B_EXT = 4'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_5B    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_OCT5D_EXT = 4'd5;
    localparam logic [STATUS_W-1:0] ST_OCT6_EXT  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_OCT7_EXT  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 4'd8;

    // optional group identifiers, octet bits 6..5
    localparam logic [1:0] GRP_L1 = 2'd1;
    localparam logic [1:0] GRP_L2 = 2'd2;
    localparam logic [1:0] GRP_L3 = 2'd3;

    // layer 1 protocols that allow octet 5b
    localparam logic [PROTO_W-1:0] L1_V110 = 5'd1;
    localparam logic [PROTO_W-1:0] L1_V120 = 5'd8;

    typedef struct packed {
        logic [OCTET_W-1:0] octet;
        logic               last_octet;
    } bcie_in_t;

    typedef struct packed {
        logic [1:0]         coding_std;
        logic [PROTO_W-1:0] transfer_capability;
        logic [1:0]         xfer_mode;
        logic [PROTO_W-1:0] transfer_rate;
        logic               layer1_present;
        logic [PROTO_W-1:0] layer1_protocol;
        logic               layer2_present;
        logic [PROTO_W-1:0] layer2_protocol;
        logic               layer3_present;
        logic [PROTO_W-1:0] layer3_protocol;
    } bcie_fields_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [1:0]          coding_std;
        logic [PROTO_W-1:0]  transfer_capability;
        logic [1:0]          xfer_mode;
        logic [PROTO_W-1:0]  transfer_rate;
        logic                layer1_present;
        logic [PROTO_W-1:0]  layer1_protocol;
        logic                layer2_present;
        logic [PROTO_W-1:0]  layer2_protocol;
        logic                layer3_present;
        logic [PROTO_W-1:0]  layer3_protocol;
    } bcie_out_t;

endpackage

FILE: hdl/bearer_capability_ie_parser.sv
// ----------------------------------------------------------------------------
// bearer_capability_ie_parser
// decodes the contents octets of one bearer capability element, one octet
// per transfer, and gives one result transfer on the final octet
// ----------------------------------------------------------------------------
//  channel   signals                              direction  transfers
//  octet     octet_valid octet_ready octet_item   in         one per octet
//  result    result_valid result_ready result_item out       one per element
//
//  one octet per cycle while no held result stalls the input register; an octet is held
//  in the input register, and its decode plus state update are combinational from it
//  a final octet passes from the input register to the result register, which holds the result
//  rst_n clears the parse state and both valid registers
//  a held result stalls the input register only while it holds a last octet
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bearer_capability_ie_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                octet_valid,
    output logic                octet_ready,
    input  bcie_pkg::bcie_in_t  octet_item,
    output logic                result_valid,
    input  logic                result_ready,
    output bcie_pkg::bcie_out_t result_item
);

    import bcie_pkg::*;

    localparam logic [3:0] PH_OCT3  = 4'd0;
    localparam logic [3:0] PH_OCT4  = 4'd1;
    localparam logic [3:0] PH_OCT4A = 4'd2;
    localparam logic [3:0] PH_OCT4B = 4'd3;
    localparam logic [3:0] PH_OPT1  = 4'd4;
    localparam logic [3:0] PH_OCT5A = 4'd5;
    localparam logic [3:0] PH_OCT5B = 4'd6;
    localparam logic [3:0] PH_OCT5C = 4'd7;
    localparam logic [3:0] PH_OCT5D = 4'd8;
    localparam logic [3:0] PH_OPT2  = 4'd9;
    localparam logic [3:0] PH_OPT3  = 4'd10;
    localparam logic [3:0] PH_SKIP  = 4'd11;

    logic               s1_valid_reg;
    bcie_in_t           s1_data_reg;
    logic               out_valid_reg;
    bcie_out_t          out_data_reg;

    logic [3:0]         phase_reg;
    logic [3:0]         phase_next;
    logic [STATUS_W-1:0] error_reg;
    logic [STATUS_W-1:0] error_next;
    logic               seen_two_reg;
    logic               seen_two_next;
    bcie_fields_t       fields_reg;
    bcie_fields_t       fields_next;

    logic               s1_fire;
    logic               seen_eff;
    logic [3:0]         ph_upd;
    logic [STATUS_W-1:0] err_upd;
    bcie_fields_t       fld_upd;
    logic [STATUS_W-1:0] status_c;
    bcie_out_t          result_c;

    logic                ext;
    logic [1:0]          grp_id;
    logic [PROTO_W-1:0]  low5;

    // stage 1 drains; a final octet goes to the result register unless a held result blocks it
    assign s1_fire     = s1_valid_reg && (!s1_data_reg.last_octet || !out_valid_reg
                                          || result_ready);
    assign octet_ready = !s1_valid_reg || s1_fire;

    assign ext    = s1_data_reg.octet[7];
    assign grp_id = s1_data_reg.octet[6:5];
    assign low5   = s1_data_reg.octet[4:0];

    assign seen_eff = seen_two_reg || (phase_reg != PH_OCT3);

    // per-octet decode
    always_comb
    begin
        ph_upd  = phase_reg;
        err_upd = error_reg;
        fld_upd = fields_reg;
        if (error_reg == ST_OK)
        begin
            unique case (phase_reg)
                PH_OCT3:
                begin
                    if (!ext)
                    begin
                        err_upd = ST_OCT3_EXT;
                        ph_upd  = PH_SKIP;
                    end
                    else
                    begin
                        fld_upd.coding_std          = grp_id;
                        fld_upd.transfer_capability = low5;
                        ph_upd = PH_OCT4;
                    end
                end
                PH_OCT4:
                begin
                    fld_upd.xfer_mode     = grp_id;
                    fld_upd.transfer_rate = low5;
                    ph_upd = ext ? PH_OPT1 : PH_OCT4A;
                end
                PH_OCT4A:
                    ph_upd = ext ? PH_OPT1 : PH_OCT4B;
                PH_OCT4B:
                begin
                    if (!ext)
                    begin
                        err_upd = ST_OCT4B_EXT;
                        ph_upd  = PH_SKIP;
                    end
                    else
                        ph_upd = PH_OPT1;
                end
                PH_OCT5A:
                begin
                    if (ext)
                        ph_upd = PH_OPT2;
                    else if (fields_reg.layer1_protocol != L1_V110
                             && fields_reg.layer1_protocol != L1_V120)
                    begin
                        err_upd = ST_BAD_5B;
                        ph_upd  = PH_SKIP;
                    end
                    else
                        ph_upd = PH_OCT5B;
                end
                PH_OCT5B:
                    ph_upd = ext ? PH_OPT2 : PH_OCT5C;
                PH_OCT5C:
                    ph_upd = ext ? PH_OPT2 : PH_OCT5D;
                PH_OCT5D:
                begin
                    if (!ext)
                    begin
                        err_upd = ST_OCT5D_EXT;
                        ph_upd  = PH_SKIP;
                    end
                    else
                        ph_upd = PH_OPT2;
                end
                PH_OPT1, PH_OPT2, PH_OPT3:
                begin
                    // optional groups, lower layers than one already passed are ignored
                    priority if (grp_id == GRP_L1 && phase_reg == PH_OPT1)
                    begin
                        fld_upd.layer1_present  = 1'b1;
                        fld_upd.layer1_protocol = low5;
                        ph_upd = ext ? PH_OPT2 : PH_OCT5A;
                    end
                    else if (grp_id == GRP_L2 && phase_reg != PH_OPT3)
                    begin
                        if (!ext)
                        begin
                            err_upd = ST_OCT6_EXT;
                            ph_upd  = PH_SKIP;
                        end
                        else
                        begin
                            fld_upd.layer2_present  = 1'b1;
                            fld_upd.layer2_protocol = low5;
                            ph_upd = PH_OPT3;
                        end
                    end
                    else if (grp_id == GRP_L3)
                    begin
                        if (!ext)
                            err_upd = ST_OCT7_EXT;
                        else
                        begin
                            fld_upd.layer3_present  = 1'b1;
                            fld_upd.layer3_protocol = low5;
                        end
                        ph_upd = PH_SKIP;
                    end
                    else
                        ph_upd = PH_SKIP;
                end
                default:
                    ph_upd = PH_SKIP;
            endcase
        end
    end

    // status of the element on its final octet
    always_comb
    begin
        priority if (!seen_eff)
            status_c = ST_TOO_SHORT;
        else if (err_upd != ST_OK)
            status_c = err_upd;
        else if (ph_upd == PH_OCT4 || ph_upd == PH_OCT4A || ph_upd == PH_OCT4B
                 || ph_upd == PH_OCT5A || ph_upd == PH_OCT5B
                 || ph_upd == PH_OCT5C || ph_upd == PH_OCT5D)
            status_c = ST_TRUNC;
        else
            status_c = ST_OK;
    end

    always_comb
    begin
        result_c = '0;
        result_c.status = status_c;
        if (status_c == ST_OK)
        begin
            result_c.coding_std          = fld_upd.coding_std;
            result_c.transfer_capability = fld_upd.transfer_capability;
            result_c.xfer_mode           = fld_upd.xfer_mode;
            result_c.transfer_rate       = fld_upd.transfer_rate;
            result_c.layer1_present      = fld_upd.layer1_present;
            result_c.layer1_protocol     = fld_upd.layer1_protocol;
            result_c.layer2_present      = fld_upd.layer2_present;
            result_c.layer2_protocol     = fld_upd.layer2_protocol;
            result_c.layer3_present      = fld_upd.layer3_present;
            result_c.layer3_protocol     = fld_upd.layer3_protocol;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        error_next    = error_reg;
        seen_two_next = seen_two_reg;
        fields_next   = fields_reg;
        if (s1_fire)
        begin
            if (s1_data_reg.last_octet)
            begin
                phase_next    = PH_OCT3;
                error_next    = ST_OK;
                seen_two_next = 1'b0;
                fields_next   = '0;
            end
            else
            begin
                phase_next    = ph_upd;
                error_next    = err_upd;
                seen_two_next = seen_eff;
                fields_next   = fld_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OCT3;
            error_reg     <= ST_OK;
            seen_two_reg  <= 1'b0;
            fields_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            error_reg    <= error_next;
            seen_two_reg <= seen_two_next;
            fields_reg   <= fields_next;
            if (octet_ready)
                s1_valid_reg <= octet_valid;
            if (s1_fire && s1_data_reg.last_octet)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (octet_valid && octet_ready)
            s1_data_reg <= octet_item;
        if (s1_fire && s1_data_reg.last_octet)
            out_data_reg <= result_c;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_data_reg;

    `ASSERT_IMPLIES(a_error_parks, error_reg != ST_OK, phase_reg == PH_SKIP, "error without skip phase")
    `ASSERT_NEXT(a_restart, s1_fire && s1_data_reg.last_octet, phase_reg == PH_OCT3 && !seen_two_reg && error_reg == ST_OK, "no restart after final octet")
    `ASSERT_IMPLIES(a_err_zero, result_valid && result_item.status != ST_OK, !result_item.layer1_present && !result_item.layer2_present && !result_item.layer3_present && result_item.coding_std == 2'd0, "fields set with error status")
    `ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_item), "held result changed")

endmodule

FILE: verif/bearer_capability_ie_parser_tb.sv
// ----------------------------------------------------------------------------
// bearer_capability_ie_parser_tb
// self-checking bench for the bearer capability element decoder: a short
// table of hand-built elements, then random elements (mostly well formed,
// some cut short, corrupted or pure noise) under four idling patterns;
// every result transfer is checked against a typed status or an in-bench decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bearer_capability_ie_parser_tb;

    import bcie_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_OCTETS = 1900;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_REPORTS   = 10;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef enum logic [3:0] {
        P_OCT3, P_OCT4, P_OCT4A, P_OCT4B, P_OPT1, P_OCT5A, P_OCT5B,
        P_OCT5C, P_OCT5D, P_OPT2, P_OPT3, P_SKIP
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
        logic       typed;
        logic [3:0] status;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         octet_valid = 1'b0;
    logic         octet_ready;
    bcie_in_t     octet_item = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    bcie_out_t    result_item;

    parse_phase_t cur_phase;
    logic [3:0]   err_code;
    logic         seen_second;
    bcie_fields_t fields;

    bcie_out_t    pending_results[$];
    logic [7:0]   elem_octets[$];
    int           fail_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int unsigned  cycle_count = 0;

    dir_row_t directed_rows [0:25] = '{
        '{8'h00, 1'b1, TYPED, ST_TOO_SHORT},
        '{8'hff, 1'b1, TYPED, ST_TOO_SHORT},
        '{8'h00, 1'b0, PREDICTED, ST_OK},
        '{8'h90, 1'b1, TYPED, ST_OCT3_EXT},
        '{8'hff, 1'b0, PREDICTED, ST_OK},
        '{8'h7f, 1'b0, PREDICTED, ST_OK},
        '{8'h7f, 1'b0, PREDICTED, ST_OK},
        '{8'h7f, 1'b1, TYPED, ST_OCT4B_EXT},
        '{8'h80, 1'b0, PREDICTED, ST_OK},
        '{8'h00, 1'b1, TYPED, ST_TRUNC},
        '{8'h80, 1'b0, PREDICTED, ST_OK},
        '{8'h80, 1'b0, PREDICTED, ST_OK},
        '{8'h22, 1'b0, PREDICTED, ST_OK},
        '{8'h00, 1'b1, TYPED, ST_BAD_5B},
        '{8'he8, 1'b0, PREDICTED, ST_OK},
        '{8'hff, 1'b0, PREDICTED, ST_OK},
        '{8'h28, 1'b0, PREDICTED, ST_OK},
        '{8'h00, 1'b0, PREDICTED, ST_OK},
        '{8'h00, 1'b0, PREDICTED, ST_OK},
        '{8'h00, 1'b0, PREDICTED, ST_OK},
        '{8'h80, 1'b0, PREDICTED, ST_OK},
        '{8'hdf, 1'b0, PREDICTED, ST_OK},
        '{8'hff, 1'b1, PREDICTED, ST_OK},
        '{8'h80, 1'b0, PREDICTED, ST_OK},
        '{8'h80, 1'b0, PREDICTED, ST_OK},
        '{8'h40, 1'b1, TYPED, ST_OCT6_EXT}
    };

    bearer_capability_ie_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .octet_valid  (octet_valid),
        .octet_ready  (octet_ready),
        .octet_item   (octet_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_decoder();
        cur_phase   = P_OCT3;
        err_code    = ST_OK;
        seen_second = 1'b0;
        fields      = '0;
    endfunction

    function automatic void abort_element(input logic [3:0] code);
        err_code  = code;
        cur_phase = P_SKIP;
    endfunction

    // optional layer group; lowest is the lowest layer still allowed
    function automatic void take_group(input logic [7:0] o, input int lowest);
        if (o[6:5] == GRP_L1 && lowest <= 1)
        begin
            fields.layer1_present  = 1'b1;
            fields.layer1_protocol = o[4:0];
            cur_phase = o[7] ? P_OPT2 : P_OCT5A;
        end
        else if (o[6:5] == GRP_L2 && lowest <= 2)
        begin
            if (!o[7])
                abort_element(ST_OCT6_EXT);
            else
            begin
                fields.layer2_present  = 1'b1;
                fields.layer2_protocol = o[4:0];
                cur_phase = P_OPT3;
            end
        end
        else if (o[6:5] == GRP_L3)
        begin
            if (!o[7])
                abort_element(ST_OCT7_EXT);
            else
            begin
                fields.layer3_present  = 1'b1;
                fields.layer3_protocol = o[4:0];
                cur_phase = P_SKIP;
            end
        end
        else
            cur_phase = P_SKIP;
    endfunction

    function automatic void decode_octet(input bcie_in_t it, output bit has_res,
                                         output bcie_out_t res);
        logic [7:0] o;
        logic [3:0] st;
        o       = it.octet;
        has_res = 1'b0;
        res     = '0;
        if (cur_phase != P_OCT3)
            seen_second = 1'b1;
        if (err_code == ST_OK)
        begin
            case (cur_phase)
                P_OCT3:
                    if (!o[7])
                        abort_element(ST_OCT3_EXT);
                    else
                    begin
                        fields.coding_std          = o[6:5];
                        fields.transfer_capability = o[4:0];
                        cur_phase = P_OCT4;
                    end
                P_OCT4:
                begin
                    fields.xfer_mode     = o[6:5];
                    fields.transfer_rate = o[4:0];
                    cur_phase = o[7] ? P_OPT1 : P_OCT4A;
                end
                P_OCT4A: cur_phase = o[7] ? P_OPT1 : P_OCT4B;
                P_OCT4B:
                    if (!o[7])
                        abort_element(ST_OCT4B_EXT);
                    else
                        cur_phase = P_OPT1;
                P_OPT1: take_group(o, 1);
                P_OCT5A:
                    if (o[7])
                        cur_phase = P_OPT2;
                    else if (fields.layer1_protocol != L1_V110 &&
                             fields.layer1_protocol != L1_V120)
                        abort_element(ST_BAD_5B);
                    else
                        cur_phase = P_OCT5B;
                P_OCT5B: cur_phase = o[7] ? P_OPT2 : P_OCT5C;
                P_OCT5C: cur_phase = o[7] ? P_OPT2 : P_OCT5D;
                P_OCT5D:
                    if (!o[7])
                        abort_element(ST_OCT5D_EXT);
                    else
                        cur_phase = P_OPT2;
                P_OPT2: take_group(o, 2);
                P_OPT3: take_group(o, 3);
                default: cur_phase = P_SKIP;
            endcase
        end
        if (it.last_octet)
        begin
            has_res = 1'b1;
            if (!seen_second)
                st = ST_TOO_SHORT;
            else if (err_code != ST_OK)
                st = err_code;
            else if (cur_phase == P_OCT4 || cur_phase == P_OCT4A || cur_phase == P_OCT4B ||
                     cur_phase == P_OCT5A || cur_phase == P_OCT5B ||
                     cur_phase == P_OCT5C || cur_phase == P_OCT5D)
                st = ST_TRUNC;
            else
                st = ST_OK;
            res = (st == ST_OK) ? bcie_out_t'({st, fields}) : bcie_out_t'({st, 32'd0});
            clear_decoder();
        end
    endfunction

    // random element: mostly well formed, some noise, cut short or corrupted
    function automatic void build_element();
        logic [4:0] l1_proto;
        logic       ext;
        int         pick;
        int         n;
        int         k;
        elem_octets.delete();
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            n = $urandom_range(1, 8);
            repeat (n) elem_octets.push_back(8'($urandom_range(255)));
            return;
        end
        elem_octets.push_back({1'b1, 7'($urandom_range(127))});
        ext = 1'($urandom_range(1));
        elem_octets.push_back({ext, 7'($urandom_range(127))});
        if (!ext)
        begin
            ext = 1'($urandom_range(1));
            elem_octets.push_back({ext, 7'($urandom_range(127))});
            if (!ext)
                elem_octets.push_back({1'b1, 7'($urandom_range(127))});
        end
        if ($urandom_range(2) != 0)
        begin
            case ($urandom_range(2))
                0: l1_proto = L1_V110;
                1: l1_proto = L1_V120;
                default: l1_proto = 5'($urandom_range(31));
            endcase
            ext = 1'($urandom_range(1));
            elem_octets.push_back({ext, GRP_L1, l1_proto});
            if (!ext)
            begin
                if (l1_proto == L1_V110 || l1_proto == L1_V120)
                    ext = 1'($urandom_range(1));
                else
                    ext = 1'b1;
                elem_octets.push_back({ext, 7'($urandom_range(127))});
                for (k = 0; k < 3 && !ext; k++)
                begin
                    ext = (k == 2) ? 1'b1 : 1'($urandom_range(1));
                    elem_octets.push_back({ext, 7'($urandom_range(127))});
                end
            end
        end
        if ($urandom_range(2) != 0)
            elem_octets.push_back({1'b1, GRP_L2, 5'($urandom_range(31))});
        if ($urandom_range(2) != 0)
            elem_octets.push_back({1'b1, GRP_L3, 5'($urandom_range(31))});
        if ($urandom_range(3) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n) elem_octets.push_back(8'($urandom_range(255)));
        end
        if (pick < 22)
        begin
            n = $urandom_range(1, elem_octets.size());
            while (elem_octets.size() > n)
                void'(elem_octets.pop_back());
        end
        else if (pick < 34)
        begin
            n = $urandom_range(0, elem_octets.size() - 1);
            elem_octets[n][7] = ~elem_octets[n][7];
        end
        else if (pick < 42)
        begin
            n = $urandom_range(2, elem_octets.size() - 1);
            elem_octets[n] = 8'($urandom_range(255));
        end
    endfunction

    task automatic send_octet(input logic [7:0] oct, input logic last,
                              input logic typed, input logic [3:0] typed_st);
        bcie_in_t  it;
        bcie_out_t res;
        bit        has_res;
        it.octet      = oct;
        it.last_octet = last;
        decode_octet(it, has_res, res);
        if (has_res)
            pending_results.push_back(typed ? bcie_out_t'({typed_st, 32'd0}) : res);
        if ($urandom_range(99) < send_idle_pct)
        begin
            octet_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        octet_valid <= 1'b1;
        octet_item  <= it;
        do @(posedge clk); while (!octet_ready);
    endtask

    function automatic void report_failure(input string what, input bcie_out_t want,
                                           input bcie_out_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t %s: expected status %0d fields %h, got status %0d fields %h",
                     $time, what, want.status, want[31:0], got.status, got[31:0]);
    endfunction

    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    // result transfer check
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                report_failure("unexpected result", '0, result_item);
            else if (result_item !== pending_results[0])
                report_failure("result mismatch", pending_results.pop_front(), result_item);
            else
                void'(pending_results.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int ph;
        clear_decoder();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_octet(directed_rows[i].octet, directed_rows[i].last,
                       directed_rows[i].typed, directed_rows[i].status);

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            sent = 0;
            while (sent < RANDOM_OCTETS / 4)
            begin
                build_element();
                foreach (elem_octets[i])
                    send_octet(elem_octets[i], i == elem_octets.size() - 1, PREDICTED, ST_OK);
                sent += elem_octets.size();
            end
        end
        octet_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
